>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that is checked through reset as well
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/fjss_pkg.sv
// ----------------------------------------------------------------------------
// fjss_pkg
// Types, constants and the CRC16-Modbus byte step for the journal slot scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package fjss_pkg;

   // width of the index fields in the summary
   localparam int unsigned IDX_W = 13;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_MAGIC = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASED_WORD  = 1'd1;

   // register reset values
   localparam logic [31:0] RECORD_MAGIC_RESET = 32'h0000_0000;
   localparam logic [31:0] ERASED_WORD_RESET  = 32'hFFFF_FFFF;

   // CRC16-Modbus: reflected, poly 0xA001, init 0xFFFF, no final xor
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // next sequence value when no record precedes the first free slot
   localparam logic [31:0] SEQ_START = 32'd1;

   typedef struct packed {
      logic [31:0] slot_magic;
      logic [31:0] slot_sequence;
      logic [31:0] slot_high_bits;
      logic [31:0] slot_low_bits;
      logic [15:0] slot_check;
      logic        last_slot;
   } req_type;

   typedef struct packed {
      logic             record_found;
      logic [IDX_W-1:0] newest_index;
      logic [31:0]      newest_sequence;
      logic [31:0]      newest_high_bits;
      logic [31:0]      newest_low_bits;
      logic             free_found;
      logic [IDX_W-1:0] first_free_index;
      logic [31:0]      next_sequence;
      logic             compact_needed;
   } rsp_type;

   // one byte through the reflected CRC register (pure xor network)
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/flash_journal_slot_scanner.sv
// ----------------------------------------------------------------------------
// flash_journal_slot_scanner
// Scans journal slots in order and reports newest record, first free slot
// and the next append sequence once the last slot of a scan has arrived.
// ----------------------------------------------------------------------------
// One slot transfer is taken per clock. The CRC16-Modbus check over the 16
// header bytes is a pure xor network, so a slot is classified, checked and
// folded into the scan state as it leaves the input register; the summary
// is loaded into the rsp output register as the last slot leaves it. The
// rsp output register lets slots keep flowing while a summary waits; only a
// last slot arriving behind an untaken summary holds the input. Configuration
// writes take effect on the next clock and belong in idle time.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_journal_slot_scanner #(
   parameter int unsigned SLOT_COUNT = 8192
) (
   input  wire                           clock,
   input  wire                           reset,
   // slot input
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire fjss_pkg::req_type        req_data,
   // summary output
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output fjss_pkg::rsp_type             rsp_data,
   // configuration writes
   input  wire                           csr_we,
   input  wire [fjss_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [31:0]                    csr_wdata
);

   localparam int unsigned POS_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(SLOT_COUNT - 1);

   // configuration registers
   logic [31:0] record_magic_ff;
   logic [31:0] erased_word_ff;

   // input and output registers
   logic              s1_valid_ff;
   fjss_pkg::req_type s1_data_ff;
   logic              rsp_valid_ff;
   fjss_pkg::rsp_type rsp_data_ff;
   fjss_pkg::rsp_type rsp_data_in;

   // scan state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             have_rec_ff, have_rec_in;
   logic [POS_W-1:0] best_pos_ff, best_pos_in;
   logic [31:0]      best_seq_ff, best_seq_in;
   logic [31:0]      best_hi_ff, best_hi_in;
   logic [31:0]      best_lo_ff, best_lo_in;
   logic             have_free_ff, have_free_in;
   logic [POS_W-1:0] free_pos_ff, free_pos_in;
   logic [31:0]      up_seq_ff, up_seq_in;

   // handshake
   logic out_free;
   logic s1_move;
   logic is_free;
   logic is_rec;
   logic crc_ok;
   logic rec_ok;
   logic [15:0] crc_full;

   logic [POS_W+fjss_pkg::IDX_W-1:0] best_pos_ext;
   logic [POS_W+fjss_pkg::IDX_W-1:0] free_pos_ext;

   // a held slot moves on unless it closes a scan and the summary slot is busy
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && (!s1_data_ff.last_slot || out_free);
   assign req_ready = !s1_valid_ff || s1_move;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // CRC over the 16 header bytes, each word little-endian
   always_comb begin
      logic [15:0] c;
      c = fjss_pkg::CRC_INIT;
      for (int k = 0; k < 4; k++) begin
         c = fjss_pkg::crc_byte(c, s1_data_ff.slot_magic[8*k +: 8]);
      end
      for (int k = 0; k < 4; k++) begin
         c = fjss_pkg::crc_byte(c, s1_data_ff.slot_sequence[8*k +: 8]);
      end
      for (int k = 0; k < 4; k++) begin
         c = fjss_pkg::crc_byte(c, s1_data_ff.slot_high_bits[8*k +: 8]);
      end
      for (int k = 0; k < 4; k++) begin
         c = fjss_pkg::crc_byte(c, s1_data_ff.slot_low_bits[8*k +: 8]);
      end
      crc_full = c;
   end

   // slot classification; erased wins over a matching magic
   assign is_free = (s1_data_ff.slot_magic == erased_word_ff);
   assign is_rec  = (s1_data_ff.slot_magic == record_magic_ff);
   assign crc_ok  = (crc_full == s1_data_ff.slot_check);
   assign rec_ok  = !is_free && is_rec && crc_ok;

   // scan state update for the held slot
   always_comb begin
      have_rec_in  = have_rec_ff;
      best_pos_in  = best_pos_ff;
      best_seq_in  = best_seq_ff;
      best_hi_in   = best_hi_ff;
      best_lo_in   = best_lo_ff;
      have_free_in = have_free_ff;
      free_pos_in  = free_pos_ff;
      up_seq_in    = up_seq_ff;

      // first erased slot is the append target
      if (is_free && !have_free_ff) begin
         have_free_in = 1'b1;
         free_pos_in  = pos_ff;
      end

      // newest record, first one wins on equal sequence
      if (rec_ok && (!have_rec_ff || (s1_data_ff.slot_sequence > best_seq_ff))) begin
         have_rec_in = 1'b1;
         best_pos_in = pos_ff;
         best_seq_in = s1_data_ff.slot_sequence;
         best_hi_in  = s1_data_ff.slot_high_bits;
         best_lo_in  = s1_data_ff.slot_low_bits;
      end

      // next sequence only follows records before the first free slot;
      // once it wraps to zero it sticks
      if (rec_ok && !have_free_ff && (up_seq_ff != 32'd0) &&
          (s1_data_ff.slot_sequence >= up_seq_ff)) begin
         up_seq_in = s1_data_ff.slot_sequence + 32'd1;
      end

      pos_in = (pos_ff == POS_LAST) ? '0 : pos_ff + POS_W'(1);
   end

   // index fields carry the low bits of the slot position
   assign best_pos_ext = {{fjss_pkg::IDX_W{1'b0}}, best_pos_in};
   assign free_pos_ext = {{fjss_pkg::IDX_W{1'b0}}, free_pos_in};

   // summary from the updated state
   always_comb begin
      rsp_data_in.record_found     = have_rec_in;
      rsp_data_in.newest_index     = best_pos_ext[fjss_pkg::IDX_W-1:0];
      rsp_data_in.newest_sequence  = best_seq_in;
      rsp_data_in.newest_high_bits = best_hi_in;
      rsp_data_in.newest_low_bits  = best_lo_in;
      rsp_data_in.free_found       = have_free_in;
      rsp_data_in.first_free_index = free_pos_ext[fjss_pkg::IDX_W-1:0];
      rsp_data_in.next_sequence    = up_seq_in;
      rsp_data_in.compact_needed   = !have_free_in;
   end

   // control and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         record_magic_ff <= fjss_pkg::RECORD_MAGIC_RESET;
         erased_word_ff  <= fjss_pkg::ERASED_WORD_RESET;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pos_ff          <= '0;
         have_rec_ff     <= 1'b0;
         best_pos_ff     <= '0;
         best_seq_ff     <= '0;
         best_hi_ff      <= '0;
         best_lo_ff      <= '0;
         have_free_ff    <= 1'b0;
         free_pos_ff     <= '0;
         up_seq_ff       <= fjss_pkg::SEQ_START;
      end else begin
         // register writes
         if (csr_we) begin
            unique case (csr_index)
               fjss_pkg::CSR_RECORD_MAGIC: record_magic_ff <= csr_wdata;
               fjss_pkg::CSR_ERASED_WORD:  erased_word_ff  <= csr_wdata;
            endcase
         end

         // input register valid
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end

         // summary output register
         if (s1_move && s1_data_ff.last_slot) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // scan state, cleared after the summary
         if (s1_move) begin
            if (s1_data_ff.last_slot) begin
               pos_ff       <= '0;
               have_rec_ff  <= 1'b0;
               best_pos_ff  <= '0;
               best_seq_ff  <= '0;
               best_hi_ff   <= '0;
               best_lo_ff   <= '0;
               have_free_ff <= 1'b0;
               free_pos_ff  <= '0;
               up_seq_ff    <= fjss_pkg::SEQ_START;
            end else begin
               pos_ff       <= pos_in;
               have_rec_ff  <= have_rec_in;
               best_pos_ff  <= best_pos_in;
               best_seq_ff  <= best_seq_in;
               best_hi_ff   <= best_hi_in;
               best_lo_ff   <= best_lo_in;
               have_free_ff <= have_free_in;
               free_pos_ff  <= free_pos_in;
               up_seq_ff    <= up_seq_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_move && s1_data_ff.last_slot) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fjss_checker.sv
// ----------------------------------------------------------------------------
// fjss_checker
// Port-level checks on the slot scanner summary channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fjss_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input wire fjss_pkg::rsp_type rsp_data
);

   logic rsp_stall;
   logic compact_ok;
   logic newest_zero;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign compact_ok  = (rsp_data.compact_needed == !rsp_data.free_found);
   assign newest_zero = (rsp_data.newest_index == '0) &&
                        (rsp_data.newest_sequence == '0) &&
                        (rsp_data.newest_high_bits == '0) &&
                        (rsp_data.newest_low_bits == '0);

   // a summary waiting for the sink holds still
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // no summary right after reset
   `ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid)

   // compaction flag is the inverse of free space found
   `ASSERT_IMPLY(a_compact, clock, reset, rsp_valid, compact_ok)

   // with no record the newest fields read zero
   `ASSERT_IMPLY(a_no_record, clock, reset, rsp_valid && !rsp_data.record_found, newest_zero)

   // with no free slot the append target reads zero
   `ASSERT_IMPLY(a_no_free, clock, reset, rsp_valid && !rsp_data.free_found,
                 rsp_data.first_free_index == '0)

endmodule

bind flash_journal_slot_scanner fjss_checker u_fjss_checker (.*);

`default_nettype wire
